// ===== design/pcs_pkg.sv =====
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared constants, types and control records for the prime counting sieve.
// ----------------------------------------------------------------------------
package pcs_pkg;

    // Largest bound that the sieve handles; larger requests saturate to it.
    localparam int MAX_N   = 65536;
    localparam int ADDR_W  = $clog2(MAX_N);
    localparam int BOUND_W = $clog2(MAX_N + 1);
    localparam int MULT_W  = BOUND_W + 1;
    localparam int SQ_W    = 2 * BOUND_W;
    localparam int FIELD_W = 17;

    typedef logic [FIELD_W-1:0] field_t;
    typedef logic [BOUND_W-1:0] bound_t;
    typedef logic [ADDR_W-1:0]  addr_t;

    // Top level to engine.
    typedef struct packed {
        logic   start;
        bound_t bound;
        logic   ack;
    } eng_ctrl_t;

    // Engine to top level.
    typedef struct packed {
        logic   idle;
        logic   done;
        bound_t count;
    } eng_status_t;

endpackage

// ===== design/pcs_stream_if.sv =====
// ----------------------------------------------------------------------------
// pcs_stream_if
// Valid/ready channels for the bound requests and the count results.
// ----------------------------------------------------------------------------
interface pcs_bound_if;
    import pcs_pkg::*;

    logic   valid;
    logic   ready;
    field_t upper_bound;

    modport source (output valid, output upper_bound, input ready);
    modport sink   (input valid, input upper_bound, output ready);
endinterface

interface pcs_count_if;
    import pcs_pkg::*;

    logic   valid;
    logic   ready;
    field_t prime_count;

    modport source (output valid, output prime_count, input ready);
    modport sink   (input valid, input prime_count, output ready);
endinterface

// ===== design/pcs_ram.sv =====
// ----------------------------------------------------------------------------
// pcs_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module pcs_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/pcs_engine.sv =====
// ----------------------------------------------------------------------------
// pcs_engine
// Sequencer that clears the bitmap, walks the candidates and strikes out
// multiples by writing them into the bitmap memory.
// ----------------------------------------------------------------------------
module pcs_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  pcs_pkg::eng_ctrl_t   ctrl,
    output pcs_pkg::eng_status_t status
);
    import pcs_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CLEAR  = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_SQUARE = 3'd4;
    localparam logic [2:0] S_TEST   = 3'd5;
    localparam logic [2:0] S_MARK   = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    localparam bound_t FIRST_CAND = bound_t'(2);

    logic [2:0]        state_reg, state_next;
    bound_t            n_reg, n_next;
    bound_t            idx_reg, idx_next;
    bound_t            cand_reg, cand_next;
    bound_t            count_reg, count_next;
    logic [MULT_W-1:0] mult_reg, mult_next;
    logic [SQ_W-1:0]   sq_reg, sq_next;

    logic              advance;
    logic [MULT_W-1:0] mult_step;
    logic              ram_we;
    addr_t             ram_addr;
    logic              ram_wdata;
    logic              ram_rdata;

    pcs_ram #(
        .WIDTH (1),
        .DEPTH (MAX_N)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign mult_step = mult_reg + MULT_W'(cand_reg);

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        idx_next   = idx_reg;
        cand_next  = cand_reg;
        count_next = count_reg;
        mult_next  = mult_reg;
        sq_next    = sq_reg;
        advance    = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = cand_reg[ADDR_W-1:0];
        ram_wdata  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (ctrl.start)
                begin
                    n_next     = ctrl.bound;
                    idx_next   = '0;
                    count_next = '0;
                    if (ctrl.bound <= FIRST_CAND)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_CLEAR;
                    end
                end
            end
            S_CLEAR:
            begin
                ram_we   = 1'b1;
                ram_addr = idx_reg[ADDR_W-1:0];
                if (idx_reg == n_reg - bound_t'(1))
                begin
                    cand_next  = FIRST_CAND;
                    state_next = S_READ;
                end
                else
                begin
                    idx_next = idx_reg + bound_t'(1);
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!ram_rdata)
                begin
                    count_next = count_reg + bound_t'(1);
                    state_next = S_SQUARE;
                end
                else
                begin
                    advance = 1'b1;
                end
            end
            S_SQUARE:
            begin
                sq_next    = SQ_W'(cand_reg) * SQ_W'(cand_reg);
                state_next = S_TEST;
            end
            S_TEST:
            begin
                if (sq_reg >= SQ_W'(n_reg))
                begin
                    advance = 1'b1;
                end
                else
                begin
                    mult_next  = sq_reg[MULT_W-1:0];
                    state_next = S_MARK;
                end
            end
            S_MARK:
            begin
                ram_we    = 1'b1;
                ram_addr  = mult_reg[ADDR_W-1:0];
                ram_wdata = 1'b1;
                if (mult_step >= MULT_W'(n_reg))
                begin
                    advance = 1'b1;
                end
                else
                begin
                    mult_next = mult_step;
                end
            end
            S_DONE:
            begin
                if (ctrl.ack)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Move on to the next candidate, or finish once the last one is done.
        if (advance)
        begin
            if (cand_reg == n_reg - bound_t'(1))
            begin
                state_next = S_DONE;
            end
            else
            begin
                cand_next  = cand_reg + bound_t'(1);
                state_next = S_READ;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        idx_reg  <= idx_next;
        cand_reg <= cand_next;
        mult_reg <= mult_next;
        sq_reg   <= sq_next;
    end

    assign status.idle  = (state_reg == S_IDLE);
    assign status.done  = (state_reg == S_DONE);
    assign status.count = count_reg;

endmodule

// ===== design/prime_count_sieve.sv =====
// ----------------------------------------------------------------------------
// prime_count_sieve
// Counts the primes strictly below an upper bound with a sieve of
// Eratosthenes held in a one-bit bitmap memory.
// ----------------------------------------------------------------------------
// One request is handled at a time. For a bound n (saturated to MAX_N) the
// block first clears the bitmap entries below n, one per cycle, then reads
// each candidate from 2 to n-1, squares each prime found, and strikes out
// each of its multiples from the square up with one write; the run time is
// set by the single port of the bitmap memory. Bounds of 2 or less return
// a count of zero without clearing the bitmap. The result sits in an
// output register, so a new request is taken as soon as the sieve has
// handed its count over, even while that count waits to be taken.
module prime_count_sieve (
    input  logic        clk,
    input  logic        rst_n,
    pcs_bound_if.sink   req,
    pcs_count_if.source rsp
);
    import pcs_pkg::*;

    eng_ctrl_t   eng_ctrl;
    eng_status_t eng_status;
    logic        out_load;
    logic        out_valid_reg, out_valid_next;
    field_t      out_count_reg;

    pcs_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (eng_ctrl),
        .status (eng_status)
    );

    assign req.ready = eng_status.idle;

    // The output register takes the count when it is empty or being emptied.
    assign out_load = eng_status.done && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        eng_ctrl.start = req.valid && req.ready;
        if (32'(req.upper_bound) > 32'(MAX_N))
        begin
            eng_ctrl.bound = bound_t'(MAX_N);
        end
        else
        begin
            eng_ctrl.bound = bound_t'(req.upper_bound);
        end
        eng_ctrl.ack = out_load;

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_count_reg <= FIELD_W'(eng_status.count);
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.prime_count = out_count_reg;

endmodule

// ===== test/prime_count_sieve_tb.sv =====
// ----------------------------------------------------------------------------
// prime_count_sieve_tb
// Self-checking bench for the prime counting sieve. Every accepted bound is
// run through a sieve kept inside the bench, and the count it predicts is
// queued. Each count that the block hands over is checked against the
// oldest queued prediction. Directed bounds come first, then random bounds
// under several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module prime_count_sieve_tb;
    import pcs_pkg::*;

    typedef struct {
        field_t bound;
        field_t count;
    } count_pred_t;

    logic clk;
    logic rst_n;

    pcs_bound_if req_if ();
    pcs_count_if rsp_if ();

    prime_count_sieve i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    count_pred_t pending_counts[$];
    bit          sieve_marks[MAX_N];
    int unsigned src_idle_pct;
    int unsigned sink_stall_pct;
    int unsigned mismatch_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Primes strictly below the bound, with the bound saturated to MAX_N.
    function automatic field_t count_primes_below(input field_t bound);
        longint unsigned n;
        longint unsigned cand;
        longint unsigned mult;
        longint unsigned primes;
        n = (bound > MAX_N) ? MAX_N : bound;
        primes = 0;
        for (int k = 0; k < MAX_N; k++)
            sieve_marks[k] = 1'b0;
        for (cand = 2; cand < n; cand++)
        begin
            if (!sieve_marks[cand])
            begin
                primes++;
                for (mult = cand * cand; mult < n; mult += cand)
                    sieve_marks[mult] = 1'b1;
            end
        end
        return field_t'(primes);
    endfunction

    task automatic send_bound(input field_t bound);
        count_pred_t pred;
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.upper_bound <= bound;
        do
            @(posedge clk);
        while (!req_if.ready);
        pred.bound = bound;
        pred.count = count_primes_below(bound);
        pending_counts.push_back(pred);
    endtask

    // Result side: check every count taken, then pick the next ready level.
    initial
    begin
        count_pred_t pred;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_if.valid && rsp_if.ready)
            begin
                if (pending_counts.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected count %0d with no request waiting",
                                 rsp_if.prime_count);
                end
                else
                begin
                    pred = pending_counts.pop_front();
                    if (rsp_if.prime_count !== pred.count)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("bound %0d: expected count %0d, got %0d",
                                     pred.bound, pred.count, rsp_if.prime_count);
                    end
                end
            end
            rsp_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Bounds where the sieve walks no candidate or only a handful.
    task automatic test_tiny_bounds();
        for (int b = 0; b <= 13; b++)
            send_bound(field_t'(b));
    endtask

    // Squares, some of primes, and their neighbours, where striking starts exactly.
    task automatic test_prime_edges();
        send_bound(field_t'(25));
        send_bound(field_t'(49));
        send_bound(field_t'(97));
        send_bound(field_t'(100));
        send_bound(field_t'(121));
        send_bound(field_t'(122));
        send_bound(field_t'(1024));
        send_bound(field_t'(4099));
    endtask

    // The full bitmap, and a bound with every bit set that saturates.
    task automatic test_largest_bounds();
        send_bound(field_t'(MAX_N));
        send_bound(field_t'(17'h1FFFF));
    endtask

    task automatic test_random_bounds(input int unsigned idle_pct,
                                      input int unsigned stall_pct,
                                      input int unsigned num_requests);
        int unsigned pick;
        field_t      bound;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        for (int i = 0; i < num_requests; i++)
        begin
            pick = $urandom_range(7);
            // Mostly modest bounds keep the run short; a few reach further.
            if (pick == 0)
                bound = field_t'($urandom_range(16));
            else if (pick == 1)
                bound = field_t'($urandom_range(8192, 601));
            else
                bound = field_t'($urandom_range(600));
            send_bound(bound);
        end
    endtask

    initial
    begin
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        mismatch_count = 0;
        rst_n              <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.upper_bound <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_tiny_bounds();
        test_prime_edges();
        test_largest_bounds();
        test_random_bounds(0, 0, 20);
        test_random_bounds(77, 0, 20);
        test_random_bounds(0, 77, 20);
        test_random_bounds(29, 29, 20);

        req_if.valid <= 1'b0;
        while (pending_counts.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #200_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
